FILE: design/jak_pkg.sv
// ----------------------------------------------------------------------------
// Joystick autofire and key mapper package
// Shared types, register indexes, pad type codes and small lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package jak_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_PAD0_TYPE     = 3'd0;
    localparam logic [2:0] REG_PAD1_TYPE     = 3'd1;
    localparam logic [2:0] REG_PAD0_AUTOFIRE = 3'd2;
    localparam logic [2:0] REG_PAD1_AUTOFIRE = 3'd3;
    localparam logic [2:0] REG_PAD0_CODES    = 3'd4;
    localparam logic [2:0] REG_PAD1_CODES    = 3'd5;

    // Pad use codes.
    localparam logic [2:0] PT_OFF    = 3'd0;
    localparam logic [2:0] PT_PORT_A = 3'd1;
    localparam logic [2:0] PT_PORT_B = 3'd2;
    localparam logic [2:0] PT_KEYS   = 3'd3;
    localparam logic [2:0] PT_PORT_C = 3'd4;

    // Code ranges.
    localparam logic [6:0] PORT_CODE_BASE = 7'h70;
    localparam logic [6:0] PORT_CODE_TOP  = 7'h75;
    localparam logic [6:0] KEY_CODE_MAX   = 7'h66;
    localparam logic [3:0] AUTOFIRE_MAX   = 4'd9;

    // What one pad lane hands to the merge stage.
    // Event slots: 0..3 directions, 4 center make, 5 center break, 6 A, 7 B.
    typedef struct packed {
        logic [5:0]      port;
        logic [7:0]      ev_valid;
        logic [7:0]      ev_rel;
        logic [7:0][6:0] ev_code;
    } lane_out_t;

    // One tick's worth of results: three port bytes and up to sixteen events.
    typedef struct packed {
        logic [5:0]       port_a;
        logic [5:0]       port_b;
        logic [5:0]       port_c;
        logic [15:0]      mask;
        logic [15:0]      rel;
        logic [15:0][6:0] code;
    } tick_t;

    // Autofire reload period for a selector; zero means no autofire.
    function automatic logic [7:0] period_of(input logic [3:0] sel);
        logic [7:0] p;
        begin
            case (sel)
                4'd1:    p = 8'd25;
                4'd2:    p = 8'd12;
                4'd3:    p = 8'd8;
                4'd4:    p = 8'd6;
                4'd5:    p = 8'd5;
                4'd6:    p = 8'd4;
                4'd7:    p = 8'd3;
                4'd8:    p = 8'd2;
                4'd9:    p = 8'd1;
                default: p = 8'd0;
            endcase
            return p;
        end
    endfunction

    // Port bit set by a mapping code; codes outside the port range set nothing.
    function automatic logic [5:0] port_bit(input logic [6:0] code);
        logic [6:0] ofs;
        begin
            ofs = code - PORT_CODE_BASE;
            if (code >= PORT_CODE_BASE && code <= PORT_CODE_TOP)
                return 6'd1 << ofs[2:0];
            return 6'd0;
        end
    endfunction

    // A code that can be sent as a keyboard event.
    function automatic logic key_ok(input logic [6:0] code);
        return (code != 7'd0) && (code <= KEY_CODE_MAX);
    endfunction

endpackage

`default_nettype wire

FILE: design/jak_lane.sv
// ----------------------------------------------------------------------------
// Joystick pad lane
// Autofire gating, port mapping and keyboard edge events for one pad.
// ----------------------------------------------------------------------------
`default_nettype none

module jak_lane
    import jak_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        update,
    input  wire logic [5:0]  raw,
    input  wire logic [2:0]  pad_type,
    input  wire logic [7:0]  autofire,
    input  wire logic [48:0] codes,
    output lane_out_t        result
);

    logic [1:0][8:0] cnt_reg;
    logic [1:0][8:0] cnt_next;
    logic [5:0]      prev_reg;
    logic [5:0]      dat;
    logic            center;

    // Autofire counters gate the two buttons.
    always_comb
    begin
        logic [3:0] sel;
        logic [8:0] period;
        logic [8:0] c;
        dat      = raw;
        cnt_next = cnt_reg;
        for (int b = 0; b < 2; b++)
        begin
            sel = autofire[4*b +: 4];
            if (sel > AUTOFIRE_MAX)
                sel = 4'd0;
            period = {1'b0, period_of(sel)};
            c = 9'd0;
            if (raw[4+b] && sel != 4'd0)
            begin
                if (cnt_reg[b] == 9'd0)
                begin
                    c = period;
                end
                else
                begin
                    c = cnt_reg[b] - 9'd1;
                    if (c[7:0] == 8'd0)
                        c = (c + period) ^ 9'h100;
                end
                if (c[8])
                    dat[4+b] = 1'b0;
            end
            cnt_next[b] = c;
        end
    end

    // All directions released after some were held last tick.
    assign center = (dat[3:0] == 4'd0) && (prev_reg[3:0] != 4'd0);

    // Port mapping and keyboard events from the gated state.
    always_comb
    begin
        logic       is_key;
        logic       rise;
        logic       fall;
        logic [6:0] cd;
        is_key          = (pad_type == PT_KEYS);
        result.port     = 6'd0;
        result.ev_valid = 8'd0;
        result.ev_rel   = 8'd0;
        result.ev_code  = '0;
        for (int k = 0; k < 4; k++)
        begin
            cd = codes[7*k +: 7];
            if (dat[k])
                result.port = result.port | port_bit(cd);
            rise = dat[k] && !prev_reg[k];
            fall = !dat[k] && prev_reg[k];
            result.ev_valid[k] = is_key && (rise || fall) && key_ok(cd);
            result.ev_rel[k]   = fall;
            result.ev_code[k]  = cd;
        end
        // Center return: a make and then a break of the center code.
        cd = codes[28 +: 7];
        if (center)
            result.port = result.port | port_bit(cd);
        result.ev_valid[4] = is_key && center && key_ok(cd);
        result.ev_rel[4]   = 1'b0;
        result.ev_code[4]  = cd;
        result.ev_valid[5] = is_key && center && key_ok(cd);
        result.ev_rel[5]   = 1'b1;
        result.ev_code[5]  = cd;
        // Buttons A and B.
        for (int b = 0; b < 2; b++)
        begin
            cd = codes[35 + 7*b +: 7];
            if (dat[4+b])
                result.port = result.port | port_bit(cd);
            rise = dat[4+b] && !prev_reg[4+b];
            fall = !dat[4+b] && prev_reg[4+b];
            result.ev_valid[6+b] = is_key && (rise || fall) && key_ok(cd);
            result.ev_rel[6+b]   = fall;
            result.ev_code[6+b]  = cd;
        end
    end

    // Pad state advances only on ticks where some pad is in use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            prev_reg <= 6'd0;
        end
        else if (update)
        begin
            cnt_reg  <= cnt_next;
            prev_reg <= dat;
        end
    end

endmodule

`default_nettype wire

FILE: design/jak_merge.sv
// ----------------------------------------------------------------------------
// Joystick lane merge and event drain
// Resolves port ownership, joins both lanes' events and sends them one a cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module jak_merge
    import jak_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lane_out_t  lane0,
    input  wire lane_out_t  lane1,
    input  wire logic [2:0] pad0_type,
    input  wire logic [2:0] pad1_type,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            accept,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [5:0]      port_a,
    output logic [5:0]      port_b,
    output logic [5:0]      port_c,
    output logic            key_valid,
    output logic            key_release,
    output logic [6:0]      key_code,
    output logic            last
);

    tick_t       incoming;
    tick_t       pend_reg;
    tick_t       drain_reg;
    logic        pend_valid_reg;
    logic        drain_valid_reg;
    logic [15:0] low_bit;
    logic [3:0]  idx;
    logic        take;
    logic        drain_done;
    logic        load_drain;

    // Port ownership: pad 1 wins when both pads drive the same port.
    function automatic logic [5:0] pick_port(input logic [2:0] want);
        if (pad1_type == want)
            return lane1.port;
        if (pad0_type == want)
            return lane0.port;
        return 6'd0;
    endfunction

    // Join the lanes, pad 0 events first.
    always_comb
    begin
        incoming.port_a = pick_port(PT_PORT_A);
        incoming.port_b = pick_port(PT_PORT_B);
        incoming.port_c = pick_port(PT_PORT_C);
        incoming.mask   = {lane1.ev_valid, lane0.ev_valid};
        incoming.rel    = {lane1.ev_rel, lane0.ev_rel};
        incoming.code   = {lane1.ev_code, lane0.ev_code};
    end

    // Lowest pending event of the tick in the drain register.
    assign low_bit = drain_reg.mask & (~drain_reg.mask + 16'd1);

    always_comb
    begin
        idx = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (drain_reg.mask[i])
                idx = 4'(i);
        end
    end

    assign out_valid   = drain_valid_reg;
    assign port_a      = drain_reg.port_a;
    assign port_b      = drain_reg.port_b;
    assign port_c      = drain_reg.port_c;
    assign key_valid   = drain_reg.mask != 16'd0;
    assign key_release = key_valid ? drain_reg.rel[idx] : 1'b0;
    assign key_code    = key_valid ? drain_reg.code[idx] : 7'd0;
    assign last        = (drain_reg.mask & ~low_bit) == 16'd0;

    // Handshake between input, pending slot and drain register.
    assign take       = drain_valid_reg && !out_stall;
    assign drain_done = take && last;
    assign load_drain = pend_valid_reg && (!drain_valid_reg || drain_done);
    assign in_stall   = pend_valid_reg && !load_drain;
    assign accept     = in_valid && !in_stall;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            drain_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                pend_valid_reg <= 1'b1;
            else if (load_drain)
                pend_valid_reg <= 1'b0;
            if (load_drain)
                drain_valid_reg <= 1'b1;
            else if (drain_done)
                drain_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= incoming;
        if (load_drain)
            drain_reg <= pend_reg;
        else if (take)
            drain_reg.mask <= drain_reg.mask & ~low_bit;
    end

endmodule

`default_nettype wire

FILE: design/joystick_autofire_and_key_mapper.sv
// ----------------------------------------------------------------------------
// Joystick autofire and key mapper
// Two pad lanes with autofire, port mapping and keyboard events, merged.
// ----------------------------------------------------------------------------
// Each accepted request is one poll tick carrying the raw state of both pads.
// The two pad lanes handle it in the cycle it is accepted, and the tick then
// waits in a pending slot until the output register is free. A tick yields
// one result per keyboard event (pad 0 first, up to sixteen), or a single
// result with key_valid low when there is none; the port bytes repeat on
// every result and last marks the final one. Results leave one per cycle
// from the output register while out_stall is low, so that event drain sets
// the sustained tick rate. A new tick is taken while earlier results drain.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module joystick_autofire_and_key_mapper
    import jak_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [48:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  pad0_raw,
    input  wire logic [5:0]  pad1_raw,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       port_a,
    output logic [5:0]       port_b,
    output logic [5:0]       port_c,
    output logic             key_valid,
    output logic             key_release,
    output logic [6:0]       key_code,
    output logic             last
);

    logic [2:0]  pad0_type_reg;
    logic [2:0]  pad1_type_reg;
    logic [7:0]  pad0_autofire_reg;
    logic [7:0]  pad1_autofire_reg;
    logic [48:0] pad0_codes_reg;
    logic [48:0] pad1_codes_reg;
    logic        accept;
    logic        update;
    lane_out_t   lane0;
    lane_out_t   lane1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad0_type_reg     <= PT_PORT_A;
            pad1_type_reg     <= PT_OFF;
            pad0_autofire_reg <= 8'd0;
            pad1_autofire_reg <= 8'd0;
            pad0_codes_reg    <= 49'd0;
            pad1_codes_reg    <= 49'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAD0_TYPE:     pad0_type_reg     <= cfg_data[2:0];
                REG_PAD1_TYPE:     pad1_type_reg     <= cfg_data[2:0];
                REG_PAD0_AUTOFIRE: pad0_autofire_reg <= cfg_data[7:0];
                REG_PAD1_AUTOFIRE: pad1_autofire_reg <= cfg_data[7:0];
                REG_PAD0_CODES:    pad0_codes_reg    <= cfg_data;
                REG_PAD1_CODES:    pad1_codes_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Pad state is frozen while both pads are off.
    assign update = accept && ((pad0_type_reg != PT_OFF) || (pad1_type_reg != PT_OFF));

    jak_lane u_lane0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (update),
        .raw      (pad0_raw),
        .pad_type (pad0_type_reg),
        .autofire (pad0_autofire_reg),
        .codes    (pad0_codes_reg),
        .result   (lane0)
    );

    jak_lane u_lane1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (update),
        .raw      (pad1_raw),
        .pad_type (pad1_type_reg),
        .autofire (pad1_autofire_reg),
        .codes    (pad1_codes_reg),
        .result   (lane1)
    );

    jak_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lane0       (lane0),
        .lane1       (lane1),
        .pad0_type   (pad0_type_reg),
        .pad1_type   (pad1_type_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .accept      (accept),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .port_a      (port_a),
        .port_b      (port_b),
        .port_c      (port_c),
        .key_valid   (key_valid),
        .key_release (key_release),
        .key_code    (key_code),
        .last        (last)
    );

endmodule

`default_nettype wire

FILE: design/jak_checker.sv
// ----------------------------------------------------------------------------
// Joystick autofire and key mapper checker
// Port-level checks on result framing and event contents, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module jak_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [5:0] port_a,
    input wire logic [5:0] port_b,
    input wire logic [5:0] port_c,
    input wire logic       key_valid,
    input wire logic       key_release,
    input wire logic [6:0] key_code,
    input wire logic       last
);

    // A result without an event is always the only result of its tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !key_valid) |-> last)
        else $error("result without event is not the last of its tick");

    // Events carry a sendable code; empty results carry zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_valid ? (key_code != 7'd0 && key_code <= 7'h66)
                                 : (key_code == 7'd0 && !key_release)))
        else $error("bad key code or release flag");

    // A tick's results follow back to back with the same port bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=>
            (out_valid && key_valid && $stable(port_a) && $stable(port_b)
             && $stable(port_c)))
        else $error("tick results broken up or port bytes changed");

    // A stalled result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(key_code) && $stable(key_release) && $stable(last)))
        else $error("stalled result changed");

endmodule

bind joystick_autofire_and_key_mapper jak_checker u_jak_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .port_a      (port_a),
    .port_b      (port_b),
    .port_c      (port_c),
    .key_valid   (key_valid),
    .key_release (key_release),
    .key_code    (key_code),
    .last        (last)
);

`default_nettype wire

FILE: bench/jak_tick_predictor_pkg.sv
// ----------------------------------------------------------------------------
// Poll tick predictor for the joystick autofire and key mapper
// Keeps its own copy of the registers, autofire counters and last pad state,
// and works out the result stream that each accepted poll tick must produce.
// ----------------------------------------------------------------------------
`default_nettype none

package jak_tick_predictor_pkg;

    import jak_pkg::*;

    // One result as seen on the output side.
    typedef struct packed {
        logic [5:0] port_a;
        logic [5:0] port_b;
        logic [5:0] port_c;
        logic       key_valid;
        logic       key_release;
        logic [6:0] key_code;
        logic       last;
    } mapper_result_t;

    class pad_tick_predictor;

        // Register copies.
        bit [2:0]  pad_use [2];
        bit [7:0]  fire_sel [2];
        bit [48:0] key_map [2];

        // Autofire counters (pad * 2 + button) and the gated state of the last tick.
        bit [8:0]  fire_count [4];
        bit [5:0]  held_bits [2];

        // Keyboard events of the tick being predicted.
        bit [6:0]  ev_code [$];
        bit        ev_release [$];

        mapper_result_t pending_results [$];

        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned key_events;

        function new();
            pad_use[0] = PT_PORT_A;
            pad_use[1] = PT_OFF;
            foreach (fire_sel[p])
            begin
                fire_sel[p]  = 8'd0;
                key_map[p]   = 49'd0;
                held_bits[p] = 6'd0;
            end
            foreach (fire_count[i])
                fire_count[i] = 9'd0;
            mismatches   = 0;
            results_seen = 0;
            key_events   = 0;
        endfunction

        // A register write seen on the configuration port.
        function void write_reg(bit [2:0] idx, bit [48:0] data);
            case (idx)
                REG_PAD0_TYPE:     pad_use[0]  = data[2:0];
                REG_PAD1_TYPE:     pad_use[1]  = data[2:0];
                REG_PAD0_AUTOFIRE: fire_sel[0] = data[7:0];
                REG_PAD1_AUTOFIRE: fire_sel[1] = data[7:0];
                REG_PAD0_CODES:    key_map[0]  = data;
                REG_PAD1_CODES:    key_map[1]  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Reload period of the autofire counter for a selector.
        function bit [7:0] fire_period(bit [3:0] sel);
            case (sel)
                4'd1:    return 8'd25;
                4'd2:    return 8'd12;
                4'd3:    return 8'd8;
                4'd4:    return 8'd6;
                4'd5:    return 8'd5;
                4'd6:    return 8'd4;
                4'd7:    return 8'd3;
                4'd8:    return 8'd2;
                4'd9:    return 8'd1;
                default: return 8'd0;
            endcase
        endfunction

        function bit [6:0] code_at(int pad, int k);
            return key_map[pad][7*k +: 7];
        endfunction

        // Only codes 0x70..0x75 select a port bit.
        function bit [5:0] port_mask(bit [6:0] code);
            if (code >= PORT_CODE_BASE && code <= PORT_CODE_TOP)
                return 6'd1 << (code - PORT_CODE_BASE);
            return 6'd0;
        endfunction

        // All directions released now while some were held last tick.
        function bit center_return(int pad, bit [5:0] dat);
            return dat[3:0] == 4'd0 && held_bits[pad][3:0] != 4'd0;
        endfunction

        function bit [5:0] port_byte(int pad, bit [5:0] dat);
            bit [5:0] acc;
            acc = 6'd0;
            for (int k = 0; k < 4; k++)
                if (dat[k])
                    acc |= port_mask(code_at(pad, k));
            if (center_return(pad, dat))
                acc |= port_mask(code_at(pad, 4));
            if (dat[4])
                acc |= port_mask(code_at(pad, 5));
            if (dat[5])
                acc |= port_mask(code_at(pad, 6));
            return acc;
        endfunction

        // Codes outside 1..0x66 never make an event.
        function void add_key(bit [6:0] code, bit rel);
            if (code == 7'd0 || code > KEY_CODE_MAX || ev_code.size() >= 16)
                return;
            ev_code.push_back(code);
            ev_release.push_back(rel);
            key_events++;
        endfunction

        function void key_edge(int pad, bit [5:0] dat, int bitpos, int k);
            if (dat[bitpos] && !held_bits[pad][bitpos])
                add_key(code_at(pad, k), 1'b0);
            else if (!dat[bitpos] && held_bits[pad][bitpos])
                add_key(code_at(pad, k), 1'b1);
        endfunction

        // Works out the results of one accepted poll tick and queues them.
        function void predict_tick(bit [5:0] raw0, bit [5:0] raw1);
            bit [5:0] ports [3];
            bit [5:0] dat;
            bit [5:0] btn;
            bit [3:0] sel;
            bit [8:0] cnt;
            int n;
            mapper_result_t r;
            ev_code.delete();
            ev_release.delete();
            ports = '{default: 6'd0};
            // With both pads off nothing runs and no state moves.
            if (pad_use[0] != PT_OFF || pad_use[1] != PT_OFF)
            begin
                for (int p = 0; p < 2; p++)
                begin
                    dat = (p == 0) ? raw0 : raw1;
                    // Autofire gating of buttons A and B.
                    for (int b = 0; b < 2; b++)
                    begin
                        btn = 6'h10 << b;
                        sel = fire_sel[p][4*b +: 4];
                        cnt = fire_count[2*p + b];
                        if (sel > AUTOFIRE_MAX)
                            sel = 4'd0;
                        if ((dat & btn) != 6'd0 && sel != 4'd0)
                        begin
                            if (cnt == 9'd0)
                                cnt = 9'(fire_period(sel));
                            else
                            begin
                                cnt = cnt - 9'd1;
                                if (cnt[7:0] == 8'd0)
                                    cnt = (cnt + 9'(fire_period(sel))) ^ 9'h100;
                            end
                            if (cnt[8])
                                dat = dat & ~btn;
                        end
                        else
                            cnt = 9'd0;
                        fire_count[2*p + b] = cnt;
                    end
                    // Pad 1 comes second, so it wins when both pads share a port.
                    case (pad_use[p])
                        PT_PORT_A: ports[0] = port_byte(p, dat);
                        PT_PORT_B: ports[1] = port_byte(p, dat);
                        PT_PORT_C: ports[2] = port_byte(p, dat);
                        PT_KEYS:
                        begin
                            for (int k = 0; k < 4; k++)
                                key_edge(p, dat, k, k);
                            if (center_return(p, dat))
                            begin
                                add_key(code_at(p, 4), 1'b0);
                                add_key(code_at(p, 4), 1'b1);
                            end
                            key_edge(p, dat, 4, 5);
                            key_edge(p, dat, 5, 6);
                        end
                        default: ;
                    endcase
                    held_bits[p] = dat;
                end
            end
            // One result per event, or a single empty one.
            n = (ev_code.size() > 0) ? ev_code.size() : 1;
            for (int k = 0; k < n; k++)
            begin
                r = '0;
                r.port_a = ports[0];
                r.port_b = ports[1];
                r.port_c = ports[2];
                if (ev_code.size() > 0)
                begin
                    r.key_valid   = 1'b1;
                    r.key_release = ev_release[k];
                    r.key_code    = ev_code[k];
                end
                r.last = (k == n - 1);
                pending_results.push_back(r);
            end
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task compare_field(string field, logic [6:0] got, logic [6:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 results_seen, field, got, want));
        endtask

        // Compares one accepted result with the oldest one pending.
        task check_result(mapper_result_t got);
            mapper_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing pending", results_seen));
                return;
            end
            want = pending_results.pop_front();
            compare_field("port_a", got.port_a, want.port_a);
            compare_field("port_b", got.port_b, want.port_b);
            compare_field("port_c", got.port_c, want.port_c);
            compare_field("key_valid", got.key_valid, want.key_valid);
            compare_field("key_release", got.key_release, want.key_release);
            compare_field("key_code", got.key_code, want.key_code);
            compare_field("last", got.last, want.last);
        endtask

    endclass

endpackage

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Joystick autofire and key mapper testbench
// Directed poll ticks for every pad use and corner case, then random pad
// activity under many register settings, with random sender gaps, receiver
// stalls and one long receiver hold-off; results checked by a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jak_pkg::*;
    import jak_tick_predictor_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PHASE_TICKS   = 50;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam logic [2:0]  PT_UNDEFINED  = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = REG_PAD0_TYPE;
    logic [48:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [5:0]  pad0_raw  = 6'd0;
    logic [5:0]  pad1_raw  = 6'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  port_a;
    logic [5:0]  port_b;
    logic [5:0]  port_c;
    logic        key_valid;
    logic        key_release;
    logic [6:0]  key_code;
    logic        last;

    pad_tick_predictor pad_model = new();

    int unsigned stall_pct     = 0;
    int unsigned holds_asked   = 0;
    int unsigned holds_done    = 0;
    int unsigned hold_left     = 0;
    int unsigned run_left      = 0;
    int unsigned settings_used = 0;
    int unsigned ticks_sent    = 0;
    int unsigned cycle_count;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    joystick_autofire_and_key_mapper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pad0_raw    (pad0_raw),
        .pad1_raw    (pad1_raw),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .port_a      (port_a),
        .port_b      (port_b),
        .port_c      (port_c),
        .key_valid   (key_valid),
        .key_release (key_release),
        .key_code    (key_code),
        .last        (last)
    );

    // Watch both channels and the register port at each rising edge.
    always @(posedge clk)
    begin
        mapper_result_t got;
        if (cfg_we)
            pad_model.write_reg(cfg_index, cfg_data);
        if (in_valid && !in_stall)
            pad_model.predict_tick(pad0_raw, pad1_raw);
        if (out_valid && !out_stall)
        begin
            got.port_a      = port_a;
            got.port_b      = port_b;
            got.port_c      = port_c;
            got.key_valid   = key_valid;
            got.key_release = key_release;
            got.key_code    = key_code;
            got.last        = last;
            pad_model.check_result(got);
        end
    end

    // Receiver: stall runs of random length, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else if (run_left != 0)
            run_left <= run_left - 1;
        else
        begin
            out_stall <= ($urandom_range(99, 0) < stall_pct);
            run_left  <= $urandom_range(5, 0);
        end
    end

    // Run limit.
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Timed out after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // Offers one poll tick and holds it until the request is taken.
    task automatic send_tick(input logic [5:0] p0, input logic [5:0] p1);
        in_valid <= 1'b1;
        pad0_raw <= p0;
        pad1_raw <= p1;
        ticks_sent++;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops offering and waits until every pending result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pad_model.pending() != 0)
            @(posedge clk);
    endtask

    // Writes all six registers once the block is idle.
    task automatic configure(input logic [2:0] t0, input logic [2:0] t1,
                             input logic [7:0] a0, input logic [7:0] a1,
                             input logic [48:0] c0, input logic [48:0] c1);
        logic [2:0]  regs [6];
        logic [48:0] vals [6];
        regs = '{REG_PAD0_TYPE, REG_PAD1_TYPE, REG_PAD0_AUTOFIRE,
                 REG_PAD1_AUTOFIRE, REG_PAD0_CODES, REG_PAD1_CODES};
        vals = '{49'(t0), 49'(t1), 49'(a0), 49'(a1), c0, c1};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [48:0] pack_codes(input logic [6:0] up, input logic [6:0] down,
                                               input logic [6:0] left, input logic [6:0] right,
                                               input logic [6:0] center, input logic [6:0] btn_a,
                                               input logic [6:0] btn_b);
        return {btn_b, btn_a, center, right, left, down, up};
    endfunction

    // Mostly port codes and key codes, sometimes anything.
    function automatic logic [6:0] random_code();
        int unsigned r;
        r = $urandom_range(9, 0);
        if (r < 5)
            return PORT_CODE_BASE + 7'($urandom_range(5, 0));
        if (r < 9)
            return 7'($urandom_range(KEY_CODE_MAX, 1));
        return 7'($urandom_range(127, 0));
    endfunction

    function automatic logic [48:0] random_codes();
        logic [48:0] c;
        for (int k = 0; k < 7; k++)
            c[7*k +: 7] = random_code();
        return c;
    endfunction

    function automatic logic [2:0] random_use();
        case ($urandom_range(9, 0))
            0:       return PT_OFF;
            1:       return PT_PORT_C + 3'($urandom_range(3, 1));
            2, 3:    return PT_PORT_A;
            4, 5:    return PT_PORT_B;
            6:       return PT_PORT_C;
            default: return PT_KEYS;
        endcase
    endfunction

    // Mostly valid selectors, with some zero and some above nine.
    function automatic logic [7:0] random_autofire();
        logic [7:0] a;
        for (int b = 0; b < 2; b++)
            a[4*b +: 4] = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0))
                                                      : 4'($urandom_range(9, 1));
        return a;
    endfunction

    // Pads mostly hold their state; directions move more often than buttons.
    function automatic logic [5:0] next_pad(input logic [5:0] cur);
        logic [5:0] nxt;
        int unsigned r;
        r = $urandom_range(9, 0);
        if (r == 0)
            return 6'($urandom_range(63, 0));
        if (r < 3)
            return cur;
        nxt = cur;
        for (int k = 0; k < 4; k++)
            if ($urandom_range(4, 0) == 0)
                nxt[k] = ~nxt[k];
        for (int k = 4; k < 6; k++)
            if ($urandom_range(11, 0) == 0)
                nxt[k] = ~nxt[k];
        return nxt;
    endfunction

    initial
    begin
        logic [5:0]  p0;
        logic [5:0]  p1;
        logic [48:0] port_map0;
        logic [48:0] port_map1;
        logic [48:0] c0;
        logic [48:0] c1;
        logic [7:0]  a0;
        logic [7:0]  a1;
        int unsigned burst;
        bit          gaps;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: pad 0 on port A with all codes zero.
        send_tick(6'h3F, 6'h3F);
        send_tick(6'h00, 6'h00);

        // Pad 0 on keys with boundary and invalid codes, pad 1 on port A with an
        // unmapped code; fastest autofire on pad 0 A, selectors above nine too.
        port_map0 = pack_codes(7'h70, 7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76);
        port_map1 = pack_codes(7'h75, 7'h74, 7'h73, 7'h72, 7'h71, 7'h70, 7'h00);
        configure(PT_KEYS, PT_PORT_A, 8'hA9, 8'h9F,
                  pack_codes(7'h01, 7'h66, 7'h67, 7'h00, 7'h20, 7'h30, 7'h7F), port_map0);
        send_tick(6'h3F, 6'h3F);
        send_tick(6'h00, 6'h00);
        send_tick(6'h01, 6'h05);
        send_tick(6'h00, 6'h00);
        send_tick(6'h10, 6'h20);
        send_tick(6'h10, 6'h20);
        send_tick(6'h10, 6'h20);
        send_tick(6'h3F, 6'h3F);

        // Both pads off: ports clear and the pad state is left alone.
        configure(PT_OFF, PT_OFF, 8'h00, 8'h00, port_map0, port_map1);
        send_tick(6'h3F, 6'h3F);
        send_tick(6'h00, 6'h00);

        // Port B, and an undefined use on pad 1.
        configure(PT_PORT_B, PT_UNDEFINED, 8'h00, 8'h00, port_map1, port_map0);
        send_tick(6'h0F, 6'h3F);
        send_tick(6'h00, 6'h00);
        send_tick(6'h30, 6'h00);

        // Both pads on port C: pad 1 overwrites pad 0.
        configure(PT_PORT_C, PT_PORT_C, 8'h00, 8'h00, port_map0, port_map1);
        send_tick(6'h01, 6'h02);
        send_tick(6'h3F, 6'h00);
        send_tick(6'h00, 6'h00);

        // Both pads on keys: the middle tick makes sixteen events.
        configure(PT_KEYS, PT_KEYS, 8'h00, 8'h00,
                  pack_codes(7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07),
                  pack_codes(7'h60, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66));
        send_tick(6'h0F, 6'h0F);
        send_tick(6'h30, 6'h30);
        send_tick(6'h0F, 6'h0F);

        // Random phases, each with its own settings and traffic shape.
        p0 = 6'd0;
        p1 = 6'd0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            a0 = random_autofire();
            a1 = random_autofire();
            c0 = random_codes();
            c1 = random_codes();
            if (ph == 0)
            begin
                a0 = 8'hFF;
                a1 = 8'hFF;
                c0 = '1;
                c1 = '1;
            end
            else if (ph == 1)
            begin
                a0 = 8'h99;
                a1 = 8'h11;
                c1 = '0;
            end
            configure(random_use(), (ph == 1) ? PT_PORT_C : random_use(), a0, a1, c0, c1);
            case (ph % 4)
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            gaps = (ph % 2 == 1);
            if (ph == 3)
                holds_asked++;
            burst = $urandom_range(12, 1);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                p0 = next_pad(p0);
                p1 = next_pad(p1);
                send_tick(p0, p1);
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(12, 1);
                    if (gaps)
                        pause_sender($urandom_range(6, 1));
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (pad_model.pending() != 0)
            pad_model.report($sformatf("%0d results never arrived", pad_model.pending()));

        $display("Sent %0d poll ticks under %0d register settings and checked %0d results.",
                 ticks_sent, settings_used, pad_model.results_seen);
        $display("Keyboard events predicted: %0d; receiver hold-offs: %0d.",
                 pad_model.key_events, holds_done);
        if (pad_model.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
